/* rtl/pattern_escape_decoder_top_macros.svh */
// assertion macros shared by the decoder modules
`ifndef PATTERN_ESCAPE_DECODER_TOP_MACROS_SVH
`define PATTERN_ESCAPE_DECODER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PED_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ped_pkg.sv */
// types, codes and character constants of the pattern escape decoder
`default_nettype none
package ped_pkg;

	localparam int LEN_W     = 11;
	localparam int MAX_BYTES = 2048;
	localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(MAX_BYTES - 1);

	localparam logic [7:0] CHAR_BAR   = 8'h7C;
	localparam logic [7:0] CHAR_BSL   = 8'h5C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LO    = 8'h1F;
	localparam logic [7:0] CHAR_HI    = 8'h7E;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_BAD_HEX  = 3'd2,
		ST_RANGE    = 3'd3,
		ST_OPEN_ESC = 3'd4,
		ST_OPEN_HEX = 3'd5
	} ped_status_t;

	typedef struct packed {
		logic             ok;
		logic [3:0]       val;
	} ped_hex_t;

	// one result word plus its emit flag
	typedef struct packed {
		logic             emit;
		logic [7:0]       data_byte;
		logic             byte_valid;
		logic             done_res;
		ped_status_t      status;
		logic [LEN_W-1:0] length;
	} ped_result_t;

	function automatic ped_hex_t hex_value(input logic [7:0] c);
		ped_hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

/* rtl/ped_in_if.sv */
// character channel of the decoder
`default_nettype none
interface ped_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

/* rtl/ped_out_if.sv */
// decoded byte channel of the decoder
`default_nettype none
interface ped_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        done_res;
	logic [2:0]  status;
	logic [10:0] length;

	modport source (output valid, output data_byte, output byte_valid, output done_res,
		output status, output length, input ready);
	modport sink (input valid, input data_byte, input byte_valid, input done_res,
		input status, input length, output ready);
endinterface
`default_nettype wire

/* rtl/ped_cfg_if.sv */
// register write channel of the decoder
`default_nettype none
interface ped_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] wdata;

	modport source (output valid, output wdata, input ready);
	modport sink (input valid, input wdata, output ready);
endinterface
`default_nettype wire

/* rtl/ped_core.sv */
// decode state and per-character decode step
`default_nettype none
`include "pattern_escape_decoder_top_macros.svh"
module ped_core
	import ped_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [7:0]       char_code,
	input  wire logic             last_char,
	input  wire logic [LEN_W-1:0] max_length,
	output ped_result_t           res
);

	logic             hex_mode_q, escape_q, nibble_q, failed_q;
	logic [3:0]       high_q;
	logic [LEN_W-1:0] count_q;

	logic             hex_mode_d, escape_d, nibble_d, failed_d;
	logic [3:0]       high_d;
	logic [LEN_W-1:0] count_d;

	logic [LEN_W-1:0] limit;
	logic [LEN_W-1:0] count_inc;
	ped_hex_t         hv;
	ped_status_t      err;
	ped_status_t      end_st;
	logic             have;
	logic [7:0]       data;

	assign limit = (max_length > LIMIT_CAP) ? LIMIT_CAP : max_length;
	assign hv    = hex_value(char_code);

	always_comb begin
		hex_mode_d = hex_mode_q;
		escape_d   = escape_q;
		nibble_d   = nibble_q;
		high_d     = high_q;
		count_d    = count_q;
		failed_d   = failed_q;
		err        = ST_OK;
		end_st     = ST_OK;
		have       = 1'b0;
		data       = 8'd0;
		count_inc  = count_q;
		res        = '{emit: 1'b0, data_byte: 8'd0, byte_valid: 1'b0, done_res: 1'b0,
			status: ST_OK, length: count_q};

		if (failed_q) begin
			// rest of a failed pattern is swallowed
			if (last_char) begin
				hex_mode_d = 1'b0;
				escape_d   = 1'b0;
				nibble_d   = 1'b0;
				high_d     = 4'd0;
				count_d    = '0;
				failed_d   = 1'b0;
			end
		end else begin
			if (count_q >= limit) begin
				err = ST_OVERFLOW;
			end else if (char_code == CHAR_BAR || char_code == CHAR_BSL) begin
				if (escape_q) begin
					escape_d = 1'b0;
					have     = 1'b1;
					data     = char_code;
				end else if (char_code == CHAR_BSL) begin
					escape_d = 1'b1;
				end else if (hex_mode_q) begin
					// closing bar drops an odd digit
					hex_mode_d = 1'b0;
					nibble_d   = 1'b0;
					high_d     = 4'd0;
				end else begin
					hex_mode_d = 1'b1;
				end
			end else if (hex_mode_q) begin
				if (hv.ok) begin
					if (!nibble_q) begin
						high_d   = hv.val;
						nibble_d = 1'b1;
					end else begin
						nibble_d = 1'b0;
						have     = 1'b1;
						data     = {high_q, hv.val};
						high_d   = 4'd0;
					end
				end else if (char_code != CHAR_SPACE) begin
					err = ST_BAD_HEX;
				end
			end else if ((char_code >= CHAR_LO && char_code <= CHAR_HI) || escape_q) begin
				escape_d = 1'b0;
				have     = 1'b1;
				data     = char_code;
			end else begin
				err = ST_RANGE;
			end

			count_inc = count_q + LEN_W'(have);
			if (escape_d)
				end_st = ST_OPEN_ESC;
			else if (hex_mode_d)
				end_st = ST_OPEN_HEX;

			if (err != ST_OK) begin
				res.emit     = 1'b1;
				res.done_res = 1'b1;
				res.status   = err;
				failed_d     = !last_char;
			end else begin
				count_d = count_inc;
				if (last_char) begin
					res.emit     = 1'b1;
					res.done_res = 1'b1;
					if (end_st != ST_OK) begin
						res.status = end_st;
					end else begin
						res.data_byte  = data;
						res.byte_valid = have;
						res.length     = count_inc;
					end
				end else if (have) begin
					res.emit       = 1'b1;
					res.data_byte  = data;
					res.byte_valid = 1'b1;
					res.length     = count_inc;
				end
			end

			if (last_char) begin
				hex_mode_d = 1'b0;
				escape_d   = 1'b0;
				nibble_d   = 1'b0;
				high_d     = 4'd0;
				count_d    = '0;
				failed_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_mode_q <= 1'b0;
			escape_q   <= 1'b0;
			nibble_q   <= 1'b0;
			high_q     <= 4'd0;
			count_q    <= '0;
			failed_q   <= 1'b0;
		end else if (fire) begin
			hex_mode_q <= hex_mode_d;
			escape_q   <= escape_d;
			nibble_q   <= nibble_d;
			high_q     <= high_d;
			count_q    <= count_d;
			failed_q   <= failed_d;
		end
	end

	`PED_ASSERT_NEXT(a_last_clears, fire && last_char,
		count_q == '0 && !hex_mode_q && !escape_q && !failed_q, "state not cleared at end")
	`PED_ASSERT_HOLDS(a_byte_ok, res.emit && res.byte_valid, res.status == ST_OK,
		"byte word with error status")
	`PED_ASSERT_HOLDS(a_mid_has_byte, res.emit && !res.done_res, res.byte_valid,
		"mid-pattern word without byte")

endmodule
`default_nettype wire

/* rtl/pattern_escape_decoder_top.sv */
// top level of the pattern escape decoder
// Decodes the characters of a quoted pattern into bytes, at most one word per character: a bar
// toggles hex mode (pairs of hex digits make a byte, spaces are skipped, an odd digit is
// dropped at the closing bar), a backslash makes the next character literal, and outside
// hex mode 0x1F..0x7E pass through. Overflow, bad hex digit, out-of-range character, open
// escape and open hex mode end the pattern with an error word; the rest of that pattern up
// to its last character is swallowed. Throughput is one character per clock while the skid
// register is empty. A character is registered in the input register and its result word,
// if any, in the output register, or in the skid register while the output is stalled. The
// skid keeps pattern_in.ready free of any path from byte_out.ready. cfg.ready is always
// high. The user writes max_length through cfg only while the block is idle; not enforced.
`default_nettype none
`include "pattern_escape_decoder_top_macros.svh"
module pattern_escape_decoder_top
	import ped_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	ped_in_if.sink     pattern_in,
	ped_out_if.source  byte_out,
	ped_cfg_if.sink    cfg
);

	// limit register
	logic [LEN_W-1:0] max_length_q;

	// input register stage
	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;

	// output register and skid
	logic             out_valid_q;
	logic             skid_valid_q;
	ped_result_t      out_q;
	ped_result_t      skid_q;
	ped_result_t      res;

	logic             advance;
	logic             out_free;

	// stage 1 moves on whenever the skid has room for its possible word
	assign advance          = valid_s1 && !skid_valid_q;
	assign pattern_in.ready = !valid_s1 || !skid_valid_q;
	assign out_free         = !out_valid_q || byte_out.ready;
	assign cfg.ready        = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_length_q <= LIMIT_CAP;
		else if (cfg.valid)
			max_length_q <= cfg.wdata;
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pattern_in.ready)
			valid_s1 <= pattern_in.valid;
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (pattern_in.valid && pattern_in.ready) begin
			char_s1 <= pattern_in.char_code;
			last_s1 <= pattern_in.last_char;
		end
	end

	ped_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.char_code  (char_s1),
		.last_char  (last_s1),
		.max_length (max_length_q),
		.res        (res)
	);

	// output and skid control: skid fills only while the output word is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= advance && res.emit;
			end
		end else if (advance && res.emit) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (advance && res.emit)
				out_q <= res;
		end else if (advance && res.emit) begin
			skid_q <= res;
		end
	end

	assign byte_out.valid      = out_valid_q;
	assign byte_out.data_byte  = out_q.data_byte;
	assign byte_out.byte_valid = out_q.byte_valid;
	assign byte_out.done_res   = out_q.done_res;
	assign byte_out.status     = out_q.status;
	assign byte_out.length     = out_q.length;

	`PED_ASSERT_HOLDS(a_skid_behind_out, skid_valid_q, out_valid_q,
		"skid word without output word")
	`PED_ASSERT_HOLDS(a_skid_fill, $rose(skid_valid_q), $past(out_valid_q && !byte_out.ready),
		"skid filled while output free")
	`PED_ASSERT_NEXT(a_stage_holds, valid_s1 && skid_valid_q, valid_s1,
		"input stage lost while skid full")

endmodule
`default_nettype wire
